>>> hw/rtl/dtrf_pkg.sv
// Package: dirty tile run finder constants, widths and index lookup tables.
`timescale 1ns / 1ps
package dtrf_pkg;

	localparam int TILE_COLUMNS = 16;
	localparam int TILE_ROWS    = 8;
	localparam int MAX_RUN      = 4;

	localparam int SHADOW_DEPTH = 128;
	localparam int IDX_W        = $clog2(SHADOW_DEPTH);
	localparam int TILE_W       = 64;
	localparam int TILE_TOTAL   = TILE_COLUMNS * TILE_ROWS;
	localparam int TILE_LIMIT   = (TILE_TOTAL < SHADOW_DEPTH) ? TILE_TOTAL : SHADOW_DEPTH;
	localparam int LEN_W        = $clog2(MAX_RUN + 1);
	localparam int NEXT_W       = IDX_W + 1;

	// input word layout
	localparam int IN_DATA_W    = 72;
	// output word layout
	localparam int COL_OUT_W    = 4;
	localparam int ROW_OUT_W    = 3;
	localparam int TILES_OUT_W  = 3;
	localparam int REGION_W     = COL_OUT_W + ROW_OUT_W + TILES_OUT_W;
	localparam int OUT_DATA_W   = 16;

	localparam logic OP_COMPARE = 1'b0;
	localparam logic OP_LOAD    = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [TILE_W-1:0] tile_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef idx_t idx_tab_t [SHADOW_DEPTH];

	typedef struct packed {
		logic [COL_OUT_W-1:0]   column;
		logic [ROW_OUT_W-1:0]   row;
		logic [TILES_OUT_W-1:0] tiles;
	} region_t;

	// column of each tile index (index mod TILE_COLUMNS), built by counting
	function automatic idx_tab_t build_col_tab();
		idx_tab_t t;
		int c;
		c = 0;
		for (int i = 0; i < SHADOW_DEPTH; i++) begin
			t[i] = IDX_W'(c);
			c = c + 1;
			if (c == TILE_COLUMNS) begin
				c = 0;
			end
		end
		return t;
	endfunction

	// row of each tile index (index div TILE_COLUMNS)
	function automatic idx_tab_t build_row_tab();
		idx_tab_t t;
		int c;
		int r;
		c = 0;
		r = 0;
		for (int i = 0; i < SHADOW_DEPTH; i++) begin
			t[i] = IDX_W'(r);
			c = c + 1;
			if (c == TILE_COLUMNS) begin
				c = 0;
				r = r + 1;
			end
		end
		return t;
	endfunction

	localparam idx_tab_t COL_TAB = build_col_tab();
	localparam idx_tab_t ROW_TAB = build_row_tab();

endpackage

>>> hw/rtl/dtrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dtrf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/dirty_tile_run_finder_unit.sv
// Top level: dirty tile run finder, shadow RAM compare and run detection.
`timescale 1ns / 1ps
// Dirty tile run finder.
// Slave stream: one word per tile. s_tuser = operation (compare or load),
// s_tdata = tile index and 64-bit tile data. Tiles of a frame come in
// ascending index order. Indices at or above the tile count are dropped.
// Master stream: one word per changed run: column, row, tile count.
// Run path: the edge that accepts the tile word that closes a run starts
// the shadow RAM read, and the next edge does the compare and run update
// and queues the run word for m_tdata.
// Throughput: one tile word per cycle while s_tready is high; the shadow RAM
// has one read and one write port, and the write of the previous tile is
// forwarded into the compare so back-to-back tiles at the same index see
// current data. Run words go through a two-entry output queue; s_tready
// drops only when that queue plus the tile in the compare stage could
// overflow it, i.e. when the master side stalls.
// Reset clears the pending run and the output queue. The shadow RAM is not
// cleared: it must be written by a load or compare before it is compared.
module dirty_tile_run_finder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dtrf_pkg::IN_DATA_W-1:0]     s_tdata,  // [6:0] tile_index, [70:7] tile_data
	input  logic                               s_tuser,  // [0] operation
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dtrf_pkg::OUT_DATA_W-1:0]    m_tdata   // [3:0] region_column,
	                                                     // [6:4] region_row, [9:7] region_tiles
);
	import dtrf_pkg::*;

	// input unpack
	idx_t  in_idx;
	tile_t in_data;
	logic  in_accept;
	logic  in_range;

	assign in_idx    = s_tdata[IDX_W-1:0];
	assign in_data   = s_tdata[IDX_W +: TILE_W];
	assign in_accept = s_tvalid && s_tready;
	assign in_range  = (NEXT_W'(in_idx) < NEXT_W'(TILE_LIMIT));

	// stage 1: tile waiting for its shadow read data
	logic  valid_s1;
	logic  op_s1;
	idx_t  idx_s1;
	tile_t data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept && in_range;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= s_tuser;
		idx_s1  <= in_idx;
		data_s1 <= in_data;
	end

	// shadow RAM
	logic  shadow_we;
	tile_t shadow_rdata;

	dtrf_ram #(
		.WIDTH(TILE_W),
		.DEPTH(SHADOW_DEPTH)
	) u_shadow (
		.clk  (clk),
		.we   (shadow_we),
		.waddr(idx_s1),
		.wdata(data_s1),
		.raddr(in_idx),
		.rdata(shadow_rdata)
	);

	// forward the write made on the same edge as the stage 1 read
	logic  fwd_valid_q;
	idx_t  fwd_idx_q;
	tile_t fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= shadow_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_idx_q  <= idx_s1;
		fwd_data_q <= data_s1;
	end

	tile_t shadow_val;
	assign shadow_val = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_data_q : shadow_rdata;

	// pending run state; full and next index kept precomputed
	idx_t              run_start_q;
	len_t              run_len_q;
	logic              run_full_q;
	logic [NEXT_W-1:0] run_next_q;

	logic              is_cmp;
	logic              differs;
	logic              pending;
	logic              row_end;
	logic              emit_old;
	logic              emit_new;
	len_t              len_new;
	logic              full_new;
	idx_t              start_new;
	logic [NEXT_W-1:0] next_new;
	logic              produce;
	idx_t              emit_start;
	len_t              emit_len;
	region_t           emit_region;
	logic [7:0]        emit_len_ext;

	always_comb begin
		is_cmp    = valid_s1 && op_s1 == OP_COMPARE;
		differs   = shadow_val != data_s1;
		pending   = run_len_q != '0;
		row_end   = COL_TAB[idx_s1] == IDX_W'(TILE_COLUMNS - 1);
		emit_old  = is_cmp && pending
		            && (run_full_q || run_next_q != NEXT_W'(idx_s1));
		shadow_we = valid_s1 && (op_s1 == OP_LOAD || differs);

		// extend the run or start a fresh one at this tile
		if (!pending || emit_old) begin
			start_new = idx_s1;
			len_new   = LEN_W'(1);
		end else begin
			start_new = run_start_q;
			len_new   = run_len_q + LEN_W'(1);
		end
		full_new = (len_new >= LEN_W'(MAX_RUN)) || row_end;
		next_new = NEXT_W'(idx_s1) + NEXT_W'(1);

		// run closes at once only when nothing went out this tile
		emit_new = is_cmp && differs && !emit_old && full_new;
		// unchanged tile ends the pending run
		if (is_cmp && !differs && pending && !emit_old) begin
			emit_new = 1'b1;
		end

		produce = emit_old || emit_new;
		if (emit_old) begin
			emit_start = run_start_q;
			emit_len   = run_len_q;
		end else if (differs) begin
			emit_start = start_new;
			emit_len   = len_new;
		end else begin
			emit_start = run_start_q;
			emit_len   = run_len_q;
		end
		emit_len_ext       = 8'(emit_len);
		emit_region.column = COL_TAB[emit_start][COL_OUT_W-1:0];
		emit_region.row    = ROW_TAB[emit_start][ROW_OUT_W-1:0];
		emit_region.tiles  = emit_len_ext[TILES_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= '0;
			run_len_q   <= '0;
			run_full_q  <= 1'b0;
			run_next_q  <= '0;
		end else if (valid_s1) begin
			if (op_s1 == OP_LOAD) begin
				// load discards the pending run
				run_start_q <= '0;
				run_len_q   <= '0;
				run_full_q  <= 1'b0;
			end else if (differs && !emit_new) begin
				run_start_q <= start_new;
				run_len_q   <= len_new;
				run_full_q  <= full_new;
				run_next_q  <= next_new;
			end else if (emit_old || emit_new) begin
				run_start_q <= '0;
				run_len_q   <= '0;
				run_full_q  <= 1'b0;
			end
		end
	end

	// two-entry output queue
	region_t    fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push = produce;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= emit_region;
		end
	end

	// column in the low bits, then row, then tile count
	assign m_tvalid = count_q != '0;
	assign m_tdata  = OUT_DATA_W'({fifo_q[rd_ptr_q].tiles, fifo_q[rd_ptr_q].row,
	                               fifo_q[rd_ptr_q].column});

	// room for the stage 1 tile's word and one more from the next tile
	assign s_tready = (3'(count_q) + 3'(valid_s1)) <= (3'd1 + 3'(pop));

endmodule

>>> dv/dirty_tile_run_finder_unit_test.sv
// Testbench: dirty tile run finder checked word by word against a run predictor.
`timescale 1ns / 1ps
module dirty_tile_run_finder_unit_test;
	import dtrf_pkg::*;

	localparam int   CYCLE_LIMIT   = 200000;
	localparam int   PHASE_WORDS   = 70;
	localparam int   HOLD_CYCLES   = 300;
	localparam int   DRAIN_CYCLES  = 10;
	localparam int   DIRECTED_ROWS = 24;
	localparam tile_t   ALL_ONES  = '1;
	localparam region_t NO_REGION = '0;

	// one tile word; typed rows carry their own expected region
	typedef struct packed {
		logic    op;
		idx_t    idx;
		tile_t   data;
		logic    typed;
		logic    has_region;
		region_t region;
	} tile_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // [6:0] tile_index, [70:7] tile_data
	logic                  s_tuser;   // [0] operation
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [3:0] region_column, [6:4] region_row, [9:7] region_tiles

	dirty_tile_run_finder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Directed words: loads seed the shadow, then max-length run, row end,
	// last tile, gap, two runs closing at once, and a load dropping a run.
	tile_word_t directed_words [DIRECTED_ROWS] = '{
		'{OP_LOAD,    7'd0,   64'h0,    1'b1, 1'b0, NO_REGION},
		'{OP_LOAD,    7'd1,   ALL_ONES, 1'b1, 1'b0, NO_REGION},
		'{OP_LOAD,    7'd2,   64'h0,    1'b1, 1'b0, NO_REGION},
		'{OP_LOAD,    7'd3,   64'h0,    1'b1, 1'b0, NO_REGION},
		'{OP_LOAD,    7'd4,   64'h0,    1'b1, 1'b0, NO_REGION},
		'{OP_LOAD,    7'd15,  64'h0,    1'b1, 1'b0, NO_REGION},
		'{OP_LOAD,    7'd127, ALL_ONES, 1'b1, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd0,   64'h0,    1'b1, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd1,   64'h0,    1'b0, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd2,   64'h1,    1'b0, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd3,   64'h1,    1'b0, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd4,   64'h1,    1'b1, 1'b1, '{4'd1, 3'd0, 3'd4}},
		'{OP_COMPARE, 7'd15,  64'h5,    1'b1, 1'b1, '{4'd15, 3'd0, 3'd1}},
		'{OP_COMPARE, 7'd127, ALL_ONES, 1'b1, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd127, 64'h0,    1'b1, 1'b1, '{4'd15, 3'd7, 3'd1}},
		'{OP_COMPARE, 7'd0,   64'h5,    1'b0, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd2,   64'h7,    1'b1, 1'b1, '{4'd0, 3'd0, 3'd1}},
		'{OP_COMPARE, 7'd3,   64'h1,    1'b1, 1'b1, '{4'd2, 3'd0, 3'd1}},
		'{OP_COMPARE, 7'd4,   64'h9,    1'b0, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd15,  64'h9,    1'b1, 1'b1, '{4'd4, 3'd0, 3'd1}},
		'{OP_COMPARE, 7'd0,   64'h5,    1'b1, 1'b1, '{4'd15, 3'd0, 3'd1}},
		'{OP_COMPARE, 7'd1,   64'h3,    1'b0, 1'b0, NO_REGION},
		'{OP_LOAD,    7'd1,   64'h0,    1'b1, 1'b0, NO_REGION},
		'{OP_COMPARE, 7'd2,   64'h7,    1'b1, 1'b0, NO_REGION}
	};

	tile_word_t tile_words [$];
	region_t    expected_regions [$];
	int         words_queued = 0;
	int         words_accepted = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	bit         hold_req = 1'b0;
	bit         failed = 1'b0;
	int         cycles = 0;

	// frame contents as the stimulus side knows them, for unchanged tiles
	tile_t frame_mirror [SHADOW_DEPTH];
	bit    mirror_valid [SHADOW_DEPTH];

	// run predictor state
	tile_t shadow_copy [SHADOW_DEPTH];
	int    run_first = 0;
	int    run_count = 0;

	function automatic bit run_closed();
		return run_count >= MAX_RUN || ((run_first + run_count) % TILE_COLUMNS) == 0;
	endfunction

	function automatic region_t close_run();
		region_t r;
		r.column = COL_OUT_W'(run_first % TILE_COLUMNS);
		r.row    = ROW_OUT_W'(run_first / TILE_COLUMNS);
		r.tiles  = TILES_OUT_W'(run_count);
		run_first = 0;
		run_count = 0;
		return r;
	endfunction

	// update shadow and run for one accepted tile, queue the region it closes
	function automatic void find_run_region(tile_word_t w);
		region_t got;
		bit      made;
		made = 1'b0;
		got  = NO_REGION;
		if (int'(w.idx) < TILE_LIMIT) begin
			if (w.op == OP_LOAD) begin
				shadow_copy[w.idx] = w.data;
				run_first = 0;
				run_count = 0;
			end else begin
				// gap or an already complete run closes the pending one first
				if (run_count != 0 && (run_closed() || int'(w.idx) != run_first + run_count)) begin
					got  = close_run();
					made = 1'b1;
				end
				if (shadow_copy[w.idx] != w.data) begin
					shadow_copy[w.idx] = w.data;
					if (run_count == 0) begin
						run_first = int'(w.idx);
						run_count = 1;
					end else begin
						run_count++;
					end
					// only one region per tile: a run that just filled waits
					if (!made && run_closed()) begin
						got  = close_run();
						made = 1'b1;
					end
				end else if (run_count != 0 && !made) begin
					got  = close_run();
					made = 1'b1;
				end
			end
		end
		if (w.typed) begin
			if (w.has_region) begin
				expected_regions.push_back(w.region);
			end
		end else if (made) begin
			expected_regions.push_back(got);
		end
	endfunction

	function automatic void queue_tile(tile_word_t w);
		frame_mirror[w.idx] = w.data;
		mirror_valid[w.idx] = 1'b1;
		tile_words.push_back(w);
		words_queued++;
	endfunction

	function automatic tile_t random_tile();
		return {$urandom, $urandom};
	endfunction

	// compare a written tile, changed with the given odds, or at times reload it; unwritten tiles are loaded
	function automatic void queue_random_tile(int idx, int change_pct);
		tile_word_t w;
		tile_t      prev;
		w = '0;
		w.idx = idx_t'(idx);
		prev = frame_mirror[idx];
		if (!mirror_valid[idx]) begin
			w.op   = OP_LOAD;
			w.data = random_tile();
		end else if ($urandom_range(99) < 6) begin
			w.op   = OP_LOAD;
			w.data = $urandom_range(1) ? prev : random_tile();
		end else begin
			w.op   = OP_COMPARE;
			w.data = prev;
			if ($urandom_range(99) < change_pct) begin
				case ($urandom_range(3))
					0: w.data = random_tile();
					1: w.data = ~prev;
					2: w.data = prev ^ (64'h1 << $urandom_range(TILE_W - 1));
					default: w.data = $urandom_range(1) ? ALL_ONES : '0;
				endcase
			end
		end
		queue_tile(w);
	endfunction

	// ascending frame slice with the odd gap, or a scatter of indices
	function automatic int queue_frame(int change_pct, bit scattered);
		int idx;
		int n;
		int len;
		n = 0;
		if (scattered) begin
			len = $urandom_range(8, 2);
			repeat (len) begin
				queue_random_tile($urandom_range(SHADOW_DEPTH - 1), change_pct);
				n++;
			end
		end else begin
			idx = $urandom_range(SHADOW_DEPTH - 1);
			len = $urandom_range(40, 1);
			while (idx < SHADOW_DEPTH && n < len) begin
				queue_random_tile(idx, change_pct);
				n++;
				idx += ($urandom_range(9) == 0) ? $urandom_range(3, 2) : 1;
			end
		end
		return n;
	endfunction

	// sender: one word in flight, replaced once taken
	initial begin
		tile_word_t cur;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_COMPARE;
		cur      = '0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (s_tvalid && s_tready) begin
				find_run_region(cur);
				words_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (tile_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur = tile_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {1'b0, cur.data, cur.idx};
					s_tuser  <= cur.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		region_t want;
		int      hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_regions.size() == 0) begin
					$error("unexpected region word %h", m_tdata);
					failed = 1'b1;
				end else begin
					want = expected_regions.pop_front();
					if (m_tdata[COL_OUT_W-1:0] != want.column) begin
						$error("region_column expected %0d actual %0d", want.column,
						       m_tdata[COL_OUT_W-1:0]);
						failed = 1'b1;
					end
					if (m_tdata[COL_OUT_W +: ROW_OUT_W] != want.row) begin
						$error("region_row expected %0d actual %0d", want.row,
						       m_tdata[COL_OUT_W +: ROW_OUT_W]);
						failed = 1'b1;
					end
					if (m_tdata[COL_OUT_W+ROW_OUT_W +: TILES_OUT_W] != want.tiles) begin
						$error("region_tiles expected %0d actual %0d", want.tiles,
						       m_tdata[COL_OUT_W+ROW_OUT_W +: TILES_OUT_W]);
						failed = 1'b1;
					end
				end
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int idle_by_phase  [4];
		int stall_by_phase [4];
		int n;
		idle_by_phase  = '{0, 55, 0, 38};
		stall_by_phase = '{0, 0, 55, 38};
		for (int i = 0; i < SHADOW_DEPTH; i++) begin
			mirror_valid[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_words[i]) begin
			queue_tile(directed_words[i]);
		end
		while (words_accepted != words_queued) @(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			n = 0;
			if (ph == 0) begin
				// whole frame loaded first, then a busy frame against a held receiver
				for (int i = 0; i < SHADOW_DEPTH; i++) begin
					tile_word_t w;
					w = '0;
					w.op   = OP_LOAD;
					w.idx  = idx_t'(i);
					w.data = random_tile();
					queue_tile(w);
				end
				while (words_accepted != words_queued) @(posedge clk);
				hold_req = 1'b1;
				n += queue_frame(90, 1'b0);
			end
			while (n < PHASE_WORDS) begin
				case ($urandom_range(3))
					0: n += queue_frame(15, $urandom_range(9) == 0);
					1: n += queue_frame(50, $urandom_range(9) == 0);
					default: n += queue_frame(90, $urandom_range(9) == 0);
				endcase
			end
			while (words_accepted != words_queued) @(posedge clk);
		end

		while (expected_regions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && expected_regions.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/dtrf_pkg.sv
hw/rtl/dtrf_ram.sv
hw/rtl/dirty_tile_run_finder_unit.sv
dv/dirty_tile_run_finder_unit_test.sv
